>>> hw/rtl/cwps_pkg.sv
// cwps_pkg: shared types and constants of the credit window priority scheduler
// no dependencies
package cwps_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam logic [31:0] WINDOW_RESET    = 32'd8388608;

    localparam logic KIND_SUBMIT   = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef struct packed {
        logic [15:0] prio;
        logic [31:0] size;
        logic [15:0] tag;
    } wait_entry_t;

endpackage

>>> hw/rtl/credit_window_priority_scheduler.sv
// credit_window_priority_scheduler: top level, control, credit count and scan
// uses cwps_pkg and cwps_wait_mem
//
// Usage
//   input channel (in_valid / in_stall) carries one event item: kind, req_tag,
//   size_bytes, prio. kind submit issues at once while bytes in flight are
//   below window_bytes, else queues the request or flags dropped if full.
//   kind complete subtracts size_bytes (floor at zero) and hands out the
//   waiting entry with the smallest prio when credit allows.
//   output channel (out_valid / out_stall) gives exactly one result item
//   per event from an output register.
//   sequence: a submit, or a completion with an empty queue, passes ST_DONE
//   into the output register; otherwise the waiting store is read one
//   entry a cycle in ST_SCAN, then ST_DRAIN, ST_DECIDE and ST_DONE follow.
//   one event is in work at a time; in_stall is high while busy and while
//   a finished result cannot enter the output register because out_stall
//   holds the previous one. reset: queue empty, bytes in flight zero,
//   window_bytes = 8388608. window_bytes is written by cfg_wr_en /
//   cfg_wr_data; the user does so only while idle, the block does not check.
module credit_window_priority_scheduler
    import cwps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] req_tag,
    input  logic [31:0] size_bytes,
    input  logic [15:0] prio,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        issued,
    output logic [15:0] issued_tag,
    output logic [31:0] issued_size,
    output logic        dropped,
    output logic [6:0]  waiting_count,
    output logic [32:0] bytes_outstanding
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned TW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]             st_reg, st_next;
    logic [31:0]            window_reg, window_next;
    logic [32:0]            count_reg, count_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   best_found_reg, best_found_next;
    logic [AW-1:0]          best_idx_reg, best_idx_next;
    logic [15:0]            best_prio_reg, best_prio_next;
    logic [15:0]            best_tag_reg, best_tag_next;
    logic [31:0]            best_size_reg, best_size_next;
    logic                   res_iss_reg, res_iss_next;
    logic [15:0]            res_tag_reg, res_tag_next;
    logic [31:0]            res_size_reg, res_size_next;
    logic                   res_drop_reg, res_drop_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   o_iss_reg, o_drop_reg;
    logic [15:0]            o_tag_reg;
    logic [31:0]            o_size_reg;
    logic [6:0]             o_wait_reg;
    logic [32:0]            o_count_reg;

    logic                   accept;
    logic                   load_out;
    logic                   free_found;
    logic [AW-1:0]          free_idx;
    logic                   mem_wr_en;
    wait_entry_t            mem_wr_data;
    logic                   mem_rd_en;
    wait_entry_t            mem_rd_data;
    logic [TW+6:0]          total_ext;

    cwps_wait_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_wait_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (free_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg),
        .rd_data (mem_rd_data)
    );

    assign in_stall  = (st_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_out  = (st_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign mem_rd_en = (st_reg == ST_SCAN);
    assign total_ext = {7'd0, total_reg};

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_comb
    begin
        st_next         = st_reg;
        window_next     = window_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        rd_pend_next    = (st_reg == ST_SCAN);
        rd_idx_next     = idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_tag_next   = best_tag_reg;
        best_size_next  = best_size_reg;
        res_iss_next    = res_iss_reg;
        res_tag_next    = res_tag_reg;
        res_size_next   = res_size_reg;
        res_drop_next   = res_drop_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_wr_en       = 1'b0;
        mem_wr_data     = '{prio: prio, size: size_bytes, tag: req_tag};

        if (cfg_wr_en)
        begin
            window_next = cfg_wr_data;
        end

        // keep the best waiting entry seen so far, ties to the lower slot
        if (rd_pend_reg && valid_reg[rd_idx_reg]
            && (!best_found_reg || mem_rd_data.prio < best_prio_reg))
        begin
            best_found_next = 1'b1;
            best_idx_next   = rd_idx_reg;
            best_prio_next  = mem_rd_data.prio;
            best_tag_next   = mem_rd_data.tag;
            best_size_next  = mem_rd_data.size;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_iss_next  = 1'b0;
                    res_tag_next  = '0;
                    res_size_next = '0;
                    res_drop_next = 1'b0;
                    st_next       = ST_DONE;
                    if (kind == KIND_SUBMIT)
                    begin
                        if (count_reg < {1'b0, window_reg})
                        begin
                            count_next    = count_reg + {1'b0, size_bytes};
                            res_iss_next  = 1'b1;
                            res_tag_next  = req_tag;
                            res_size_next = size_bytes;
                        end
                        else if (free_found)
                        begin
                            mem_wr_en            = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            total_next           = total_reg + TW'(1);
                        end
                        else
                        begin
                            res_drop_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if ({1'b0, size_bytes} >= count_reg)
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg - {1'b0, size_bytes};
                        end
                        if (total_reg != '0)
                        begin
                            best_found_next = 1'b0;
                            idx_next        = '0;
                            st_next         = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(QUEUE_DEPTH - 1))
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                st_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (best_found_reg && count_reg < {1'b0, window_reg})
                begin
                    valid_next[best_idx_reg] = 1'b0;
                    total_next               = total_reg - TW'(1);
                    count_next               = count_reg + {1'b0, best_size_reg};
                    res_iss_next             = 1'b1;
                    res_tag_next             = best_tag_reg;
                    res_size_next            = best_size_reg;
                end
                st_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            window_reg     <= WINDOW_RESET;
            count_reg      <= '0;
            valid_reg      <= '0;
            total_reg      <= '0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            window_reg     <= window_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            total_reg      <= total_next;
            idx_reg        <= idx_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_tag_reg  <= best_tag_next;
        best_size_reg <= best_size_next;
        res_iss_reg   <= res_iss_next;
        res_tag_reg   <= res_tag_next;
        res_size_reg  <= res_size_next;
        res_drop_reg  <= res_drop_next;
        if (load_out)
        begin
            o_iss_reg   <= res_iss_reg;
            o_tag_reg   <= res_tag_reg;
            o_size_reg  <= res_size_reg;
            o_drop_reg  <= res_drop_reg;
            o_wait_reg  <= total_ext[6:0];
            o_count_reg <= count_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign issued            = o_iss_reg;
    assign issued_tag        = o_tag_reg;
    assign issued_size       = o_size_reg;
    assign dropped           = o_drop_reg;
    assign waiting_count     = o_wait_reg;
    assign bytes_outstanding = o_count_reg;

    a_total_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(total_reg))
        else $error("waiting total out of step with valid bits");

    a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= QUEUE_DEPTH)
        else $error("waiting total above queue depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_DECIDE |-> best_found_reg)
        else $error("scan finished without a waiting entry");

endmodule

>>> hw/rtl/cwps_wait_mem.sv
// cwps_wait_mem: dual port synchronous store for the waiting entries
// uses cwps_pkg for the entry layout, read data registered
module cwps_wait_mem
    import cwps_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  wait_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output wait_entry_t       rd_data
);

    wait_entry_t mem [DEPTH];
    wait_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/cwps_checker.sv
`timescale 1ns / 1ps
// cwps_checker: watches the event and result channels of the scheduler,
// predicts each result from its own copy of the credit count and wait queue
// uses cwps_pkg; driven by tb
module cwps_checker
    import cwps_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [15:0] req_tag,
    input  logic [31:0] size_bytes,
    input  logic [15:0] prio,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        issued,
    input  logic [15:0] issued_tag,
    input  logic [31:0] issued_size,
    input  logic        dropped,
    input  logic [6:0]  waiting_count,
    input  logic [32:0] bytes_outstanding,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic        issued;
        logic [15:0] tag;
        logic [31:0] size;
        logic        dropped;
        logic [6:0]  waiting;
        logic [32:0] bytes;
    } sched_result_t;

    logic [31:0]  window;
    logic [32:0]  in_flight;
    wait_entry_t  slot [DEPTH];
    logic [DEPTH-1:0] slot_used;
    logic [6:0]   waiting;
    sched_result_t expected_q [$];

    function automatic sched_result_t schedule_event(logic k, logic [15:0] t,
                                                     logic [31:0] s, logic [15:0] p);
        sched_result_t r;
        int best;
        r = '0;
        if (k == KIND_SUBMIT) begin
            if (in_flight < {1'b0, window}) begin
                in_flight = in_flight + {1'b0, s};
                r.issued = 1'b1;
                r.tag = t;
                r.size = s;
            end else begin
                r.dropped = 1'b1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (r.dropped && !slot_used[i]) begin
                        slot[i] = '{prio: p, size: s, tag: t};
                        slot_used[i] = 1'b1;
                        waiting = waiting + 7'd1;
                        r.dropped = 1'b0;
                    end
                end
            end
        end else begin
            in_flight = ({1'b0, s} >= in_flight) ? 33'd0 : in_flight - {1'b0, s};
            best = -1;
            for (int i = 0; i < DEPTH; i++)
                if (slot_used[i] && (best < 0 || slot[i].prio < slot[best].prio))
                    best = i;
            if (best >= 0 && in_flight < {1'b0, window}) begin
                slot_used[best] = 1'b0;
                if (waiting != 0)
                    waiting = waiting - 7'd1;
                in_flight = in_flight + {1'b0, slot[best].size};
                r.issued = 1'b1;
                r.tag = slot[best].tag;
                r.size = slot[best].size;
            end
        end
        r.waiting = waiting;
        r.bytes = in_flight;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got;
        sched_result_t want;
        sched_result_t pred;
        if (!rst_n) begin
            window = WINDOW_RESET;
            in_flight = '0;
            slot_used = '0;
            waiting = '0;
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{issued, issued_tag, issued_size, dropped, waiting_count,
                        bytes_outstanding};
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"mismatch: expected iss=%b tag=%h size=%h ",
                                      "drop=%b wait=%0d bytes=%h, got iss=%b tag=%h ",
                                      "size=%h drop=%b wait=%0d bytes=%h"},
                                     want.issued, want.tag, want.size, want.dropped,
                                     want.waiting, want.bytes, got.issued, got.tag,
                                     got.size, got.dropped, got.waiting, got.bytes);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                pred = schedule_event(kind, req_tag, size_bytes, prio);
                expected_q = {expected_q, pred};
            end
            if (cfg_wr_en)
                window = cfg_wr_data;
            pending <= expected_q.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for credit_window_priority_scheduler
// uses cwps_pkg, the scheduler rtl and cwps_checker
module tb;
    import cwps_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [15:0] req_tag;
    logic [31:0] size_bytes;
    logic [15:0] prio;
    logic        out_valid;
    logic        out_stall;
    logic        issued;
    logic [15:0] issued_tag;
    logic [31:0] issued_size;
    logic        dropped;
    logic [6:0]  waiting_count;
    logic [32:0] bytes_outstanding;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          idle_cycles;
    int          stall_left;
    logic        stall_enable;

    credit_window_priority_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .req_tag(req_tag), .size_bytes(size_bytes), .prio(prio),
        .out_valid(out_valid), .out_stall(out_stall),
        .issued(issued), .issued_tag(issued_tag), .issued_size(issued_size),
        .dropped(dropped), .waiting_count(waiting_count),
        .bytes_outstanding(bytes_outstanding)
    );

    cwps_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure, mostly short stalls and a few long ones
    always @(posedge clk)
    begin
        if (!stall_enable)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            out_stall  <= 1'b1;
            stall_left <= gap_length();
        end
        else
        begin
            out_stall  <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall || out_valid && !out_stall || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_event(logic k, logic [15:0] t, logic [31:0] s, logic [15:0] p);
        int g;
        g = gap_length();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        req_tag <= t;
        size_bytes <= s;
        prio <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_window(logic [31:0] w);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n, int max_size);
        logic [31:0] s;
        for (int i = 0; i < n; i++)
        begin
            s = (max_size == 0) ? $urandom() : $urandom_range(0, max_size);
            if ($urandom_range(0, 99) < 3)
                s = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            if ($urandom_range(0, 99) < 55)
                send_event(KIND_SUBMIT, 16'($urandom()), s, $urandom_range(0, 99) < 30 ?
                           16'($urandom_range(0, 3)) : 16'($urandom()));
            else
                send_event(KIND_COMPLETE, 16'($urandom()), s, 16'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        kind = KIND_SUBMIT;
        req_tag = '0;
        size_bytes = '0;
        prio = '0;
        out_stall = 1'b0;
        stall_enable = 1'b0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default window, extremes, empty-queue completion, saturation
        send_event(KIND_COMPLETE, 16'hFFFF, 32'd5, 16'hFFFF);
        send_event(KIND_SUBMIT, 16'h0000, 32'd0, 16'h0000);
        send_event(KIND_SUBMIT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_event(KIND_SUBMIT, 16'h1234, 32'd100, 16'd7);
        send_event(KIND_SUBMIT, 16'h5678, 32'd200, 16'd7);
        send_event(KIND_SUBMIT, 16'h9ABC, 32'd300, 16'd2);
        send_event(KIND_COMPLETE, 16'h0, 32'd1, 16'h0);
        send_event(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 16'h0);
        send_event(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 16'h0);
        send_event(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 16'h0);
        send_event(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 16'h0);

        // window of zero: fill the queue past full, then drain nothing
        write_window(32'd0);
        for (int i = 0; i < 68; i++)
            send_event(KIND_SUBMIT, i[15:0], $urandom(), 16'($urandom_range(0, 5)));
        send_event(KIND_COMPLETE, 16'h0, 32'd0, 16'h0);
        stall_enable = 1'b1;

        // maximum window drains everything
        write_window(32'hFFFF_FFFF);
        for (int i = 0; i < 66; i++)
            send_event(KIND_COMPLETE, 16'h0, 32'hFFFF_FFFF, 16'h0);

        write_window(32'd1);
        random_phase(450, 8);
        write_window(32'd1000);
        random_phase(450, 600);
        write_window(32'hFFFF_FFFF);
        random_phase(300, 0);
        write_window($urandom());
        random_phase(300, 0);
        write_window(WINDOW_RESET);
        random_phase(100, 4000000);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
